/* sv/skl_pkg.sv */
// shared widths and defaults for the streaming k-th largest block
package skl_pkg;

  localparam int VALUE_W   = 32;
  localparam int KSEL_W    = 7;
  localparam int K_MAX_DEF = 64;

  localparam logic [KSEL_W-1:0] KSEL_RESET = KSEL_W'(1);

endpackage

/* sv/skl_stream_if.sv */
// valid/ready channel interfaces for input elements and results

interface skl_in_if
  import skl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface skl_out_if
  import skl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] kth_value;
  logic                      fewer_than_k;

  modport source (output valid, output kth_value, output fewer_than_k, input ready);
  modport sink   (input valid, input kth_value, input fewer_than_k, output ready);
endinterface

/* sv/skl_heap_mem.sv */
// heap storage: one write port, two registered read ports
module skl_heap_mem
  import skl_pkg::*;
#(
  parameter int K_MAX = K_MAX_DEF,
  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic signed [VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr0_i,
  input  logic [AW-1:0]             raddr1_i,
  output logic signed [VALUE_W-1:0] rdata0_o,
  output logic signed [VALUE_W-1:0] rdata1_o
);

  logic signed [VALUE_W-1:0] mem_q [K_MAX];
  logic signed [VALUE_W-1:0] rdata0_q;
  logic signed [VALUE_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* sv/skl_ctrl.sv */
// heap sequencer: insert with sift-up, replace root with sift-down, report
module skl_ctrl
  import skl_pkg::*;
#(
  parameter int K_MAX = K_MAX_DEF,
  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1,
  localparam int CW = $clog2(K_MAX + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [KSEL_W-1:0]         k_sel_i,
  skl_in_if.sink                    in_i,
  skl_out_if.source                 out_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic signed [VALUE_W-1:0] mem_wdata_o,
  output logic [AW-1:0]             mem_raddr0_o,
  output logic [AW-1:0]             mem_raddr1_o,
  input  logic signed [VALUE_W-1:0] mem_rdata0_i,
  input  logic signed [VALUE_W-1:0] mem_rdata1_i
);

  localparam int KW = (CW > KSEL_W) ? CW : KSEL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             idx_q;
  logic signed [VALUE_W-1:0] val_q;
  logic                      last_q;
  logic signed [VALUE_W-1:0] root_q;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_kth_q;
  logic                      out_fewer_q;

  logic [KW-1:0]             k_ext;
  logic [KW-1:0]             k_eff;
  logic                      below_k;
  logic [CW-1:0]             parent;
  logic [CW:0]               child_l;
  logic [CW:0]               child_r;
  logic [CW:0]               n_ext;
  logic                      use_right;
  logic signed [VALUE_W-1:0] child_val;
  logic [CW-1:0]             child_idx;
  logic                      report;

  // saturate k into one to K_MAX
  always_comb begin
    k_ext = KW'(k_sel_i);
    if (k_sel_i == '0) begin
      k_eff = KW'(1);
    end else if (k_ext > KW'(K_MAX)) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = k_ext;
    end
  end

  assign below_k   = KW'(count_q) < k_eff;
  assign parent    = (idx_q - CW'(1)) >> 1;
  assign child_l   = {idx_q, 1'b1};
  assign child_r   = child_l + (CW+1)'(1);
  assign n_ext     = {1'b0, count_q};
  assign use_right = (child_r < n_ext) && (mem_rdata1_i < mem_rdata0_i);
  assign child_val = use_right ? mem_rdata1_i : mem_rdata0_i;
  assign child_idx = use_right ? child_r[CW-1:0] : child_l[CW-1:0];
  assign report    = (state_q == ST_FINISH) && last_q && (!out_valid_q || out_o.ready);

  always_comb begin
    mem_we_o     = 1'b0;
    mem_waddr_o  = idx_q[AW-1:0];
    mem_wdata_o  = val_q;
    mem_raddr0_o = parent[AW-1:0];
    mem_raddr1_o = child_r[AW-1:0];
    case (state_q)
      ST_UP_RD: begin
        mem_we_o = (idx_q == '0);
      end
      ST_UP_CMP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = (mem_rdata0_i <= val_q) ? val_q : mem_rdata0_i;
      end
      ST_DN_RD: begin
        mem_raddr0_o = child_l[AW-1:0];
        mem_we_o     = (child_l >= n_ext);
      end
      ST_DN_CMP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = (child_val >= val_q) ? val_q : child_val;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      last_q      <= 1'b0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
      out_kth_q   <= '0;
      out_fewer_q <= 1'b0;
    end else begin
      if (report) begin
        out_valid_q <= 1'b1;
        out_kth_q   <= root_q;
        out_fewer_q <= below_k;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // shadow of the root entry
      if (mem_we_o && (idx_q == '0)) begin
        root_q <= mem_wdata_o;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            val_q  <= in_i.value;
            last_q <= in_i.last;
            if (below_k) begin
              idx_q   <= count_q;
              state_q <= ST_UP_RD;
            end else if (in_i.value > root_q) begin
              idx_q   <= '0;
              state_q <= ST_DN_RD;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_UP_RD: begin
          if (idx_q == '0) begin
            count_q <= count_q + CW'(1);
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (mem_rdata0_i <= val_q) begin
            count_q <= count_q + CW'(1);
            state_q <= ST_FINISH;
          end else begin
            idx_q   <= parent;
            state_q <= ST_UP_RD;
          end
        end
        ST_DN_RD: begin
          state_q <= (child_l >= n_ext) ? ST_FINISH : ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (child_val >= val_q) begin
            state_q <= ST_FINISH;
          end else begin
            idx_q   <= child_idx;
            state_q <= ST_DN_RD;
          end
        end
        ST_FINISH: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (report) begin
            count_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.kth_value    = out_kth_q;
  assign out_o.fewer_than_k = out_fewer_q;

endmodule

/* sv/streaming_kth_largest.sv */
// top level of the streaming k-th largest block
//
// in_i carries one signed element per transfer, with last marking the
// final element of an array. out_o carries one result per array: the
// k-th largest element, or the smallest one with fewer_than_k set when
// the array held fewer than k elements.
// cfg_we_i/cfg_wdata_i write k (0 acts as 1, above K_MAX acts as K_MAX);
// write only while the block is idle.
// elements are taken one at a time: a dropped element goes straight to the
// finish state; an insert or a root replace walks the heap one level at a
// time, with one read and one compare with write-back of the heap memory
// per level, and stops as soon as a compare ends the move.
// the result is valid from the edge at which the block takes input again
// after the last element. while the receiver stalls, the next array's elements
// are still taken; only a second result waits until the first is taken.
// reset empties the heap and sets k to 1; the heap memory itself is
// not cleared and needs no clearing pass.
module streaming_kth_largest
  import skl_pkg::*;
#(
  parameter int K_MAX = K_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [KSEL_W-1:0] cfg_wdata_i,
  skl_in_if.sink            in_i,
  skl_out_if.source         out_o
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [KSEL_W-1:0]         k_sel_q;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr0;
  logic [AW-1:0]             mem_raddr1;
  logic signed [VALUE_W-1:0] mem_rdata0;
  logic signed [VALUE_W-1:0] mem_rdata1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_sel_q <= KSEL_RESET;
    end else if (cfg_we_i) begin
      k_sel_q <= cfg_wdata_i;
    end
  end

  skl_ctrl #(
    .K_MAX (K_MAX)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .k_sel_i      (k_sel_q),
    .in_i         (in_i),
    .out_o        (out_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr0_o (mem_raddr0),
    .mem_raddr1_o (mem_raddr1),
    .mem_rdata0_i (mem_rdata0),
    .mem_rdata1_i (mem_rdata1)
  );

  skl_heap_mem #(
    .K_MAX (K_MAX)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr0_i (mem_raddr0),
    .raddr1_i (mem_raddr1),
    .rdata0_o (mem_rdata0),
    .rdata1_o (mem_rdata1)
  );

endmodule

/* sv/skl_checker.sv */
// port-level assertions for the streaming k-th largest block, with bind
module skl_checker
  import skl_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [VALUE_W-1:0] out_kth_i,
  input logic                      out_fewer_i
);

  // stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kth_i) && $stable(out_fewer_i))
    else $error("result changed while stalled");

  // one element in work at a time
  a_busy_after_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an element is in work");

  // a new result only follows a cycle of element work
  a_out_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without element work");

endmodule

bind streaming_kth_largest skl_checker u_skl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kth_i   (out_o.kth_value),
  .out_fewer_i (out_o.fewer_than_k)
);

/* tb/sv/tb_top.sv */
// testbench for streaming_kth_largest: min-heap predictor, valid/ready driver and result checker
`timescale 1ns / 100ps

module tb_top;
  import skl_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } elem_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kth_value;
    logic                      fewer_than_k;
  } kth_res_t;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int N_SEG         = 14;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [KSEL_W-1:0] cfg_wdata;

  skl_in_if  in_if ();
  skl_out_if out_if ();

  streaming_kth_largest i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  elem_t    elem_q[$];
  kth_res_t kth_expect_q[$];

  logic signed [VALUE_W-1:0] heap_vals [K_MAX_DEF];
  int                        heap_size = 0;
  logic [KSEL_W-1:0]         k_reg     = KSEL_RESET;

  int src_idle  = 0;
  int snk_idle  = 0;
  bit hold_arm  = 0;
  bit hold_used = 0;
  int hold_left = 0;
  int err_cnt   = 0;

  always #5 clk_i = ~clk_i;

  function automatic int k_eff();
    int k;
    k = int'(k_reg);
    if (k == 0) k = 1;
    if (k > K_MAX_DEF) k = K_MAX_DEF;
    return k;
  endfunction

  function automatic void heap_push(input logic signed [VALUE_W-1:0] v);
    int slot;
    int parent;
    slot = heap_size;
    while (slot > 0) begin
      parent = (slot - 1) / 2;
      if (heap_vals[parent] <= v) break;
      heap_vals[slot] = heap_vals[parent];
      slot = parent;
    end
    heap_vals[slot] = v;
    heap_size++;
  endfunction

  function automatic void heap_replace_min(input logic signed [VALUE_W-1:0] v);
    int slot;
    int child;
    bit done;
    slot = 0;
    done = 0;
    while (!done) begin
      child = 2 * slot + 1;
      if (child >= heap_size) begin
        done = 1;
      end else begin
        if (child + 1 < heap_size && heap_vals[child+1] < heap_vals[child]) child++;
        if (heap_vals[child] >= v) begin
          done = 1;
        end else begin
          heap_vals[slot] = heap_vals[child];
          slot = child;
        end
      end
    end
    heap_vals[slot] = v;
  endfunction

  function automatic void heap_absorb(input elem_t e);
    int                        k;
    logic signed [VALUE_W-1:0] v;
    kth_res_t                  r;
    k = k_eff();
    v = $signed(e.value);
    if (heap_size < k && heap_size < K_MAX_DEF) heap_push(v);
    else if (v > heap_vals[0]) heap_replace_min(v);
    if (e.last) begin
      r.kth_value    = heap_vals[0];
      r.fewer_than_k = (heap_size < k);
      kth_expect_q.push_back(r);
      heap_size = 0;
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $urandom_range(16) - 32'd8;
    if (sel == 8) return $urandom_range(1) ? VAL_MAX : VAL_MIN;
    return $urandom_range(1) ? VAL_MAX - $urandom_range(3) : VAL_MIN + $urandom_range(3);
  endfunction

  // driver
  always @(posedge clk_i) begin
    elem_t nxt;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) heap_absorb('{value: in_if.value, last: in_if.last});
      if (!in_if.valid || in_if.ready) begin
        if (elem_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          nxt = elem_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.value <= nxt.value;
          in_if.last  <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    kth_res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (kth_expect_q.size() == 0) begin
          $error("unexpected result: kth_value %0d fewer_than_k %0b",
                 $signed(out_if.kth_value), out_if.fewer_than_k);
          err_cnt++;
        end else begin
          want = kth_expect_q.pop_front();
          if (out_if.kth_value !== want.kth_value) begin
            $error("kth_value: expected %0d, actual %0d",
                   $signed(want.kth_value), $signed(out_if.kth_value));
            err_cnt++;
          end
          if (out_if.fewer_than_k !== want.fewer_than_k) begin
            $error("fewer_than_k: expected %0b, actual %0b",
                   want.fewer_than_k, out_if.fewer_than_k);
            err_cnt++;
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic add_elem(input logic signed [VALUE_W-1:0] v, input logic l);
    elem_q.push_back('{value: v, last: l});
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (!(elem_q.size() == 0 && !in_if.valid && kth_expect_q.size() == 0))
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [KSEL_W-1:0] k);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    k_reg = k;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic start_seg(input int src, input int snk);
    @(negedge clk_i);
    src_idle = src;
    snk_idle = snk;
  endtask

  task automatic fill_arrays(input int n_items, input int max_len);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(max_len, 1);
      for (int i = 0; i < len && left > 0; i++) begin
        add_elem(pick_value(), i == len - 1);
        left--;
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [KSEL_W-1:0] seg_k [N_SEG];
    int                seg_n;
    int                src;
    int                snk;
    seg_k = '{7'd3, 7'd1, 7'd64, 7'd2, 7'd0, 7'd127, 7'd5, 7'd65, 7'd16, 7'd7,
              7'd1, 7'd4, 7'd64, 7'd2};
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    for (int i = 0; i < K_MAX_DEF; i++) heap_vals[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: k from reset
    start_seg(21, 80);
    add_elem(VAL_MIN, 1'b1);
    add_elem(VAL_MAX, 1'b1);
    add_elem(-5, 1'b0);
    add_elem(9, 1'b0);
    add_elem(9, 1'b1);
    settle();

    // zero acts as one
    write_k('0);
    start_seg(21, 80);
    add_elem(7, 1'b0);
    add_elem(-1, 1'b0);
    add_elem(0, 1'b1);
    settle();

    // short array, equal values, then an open array
    write_k(7'd4);
    start_seg(21, 80);
    add_elem(1, 1'b0);
    add_elem(2, 1'b1);
    for (int i = 0; i < 5; i++) add_elem(3, i == 4);
    add_elem(10, 1'b0);
    add_elem(20, 1'b0);
    add_elem(30, 1'b0);
    add_elem(40, 1'b0);
    add_elem(50, 1'b0);
    add_elem(-7, 1'b0);
    settle();

    // k lowered mid-array
    write_k(7'd2);
    start_seg(21, 80);
    add_elem(100, 1'b0);
    add_elem(-100, 1'b0);
    add_elem(45, 1'b1);
    settle();

    // saturation above the maximum
    write_k('1);
    start_seg(21, 80);
    add_elem(VAL_MAX, 1'b0);
    add_elem(VAL_MIN, 1'b0);
    add_elem(0, 1'b1);
    settle();

    // random arrays
    for (int s = 0; s < N_SEG; s++) begin
      write_k(seg_k[s]);
      if (s < 5) begin
        src = 21;
        snk = 80;
      end else if (s < 10) begin
        src = 80;
        snk = 21;
      end else begin
        src = 0;
        snk = 0;
      end
      start_seg(src, snk);
      if (s == 10) hold_arm = 1'b1;
      seg_n = (k_eff() >= 16) ? 120 : 50;
      fill_arrays(seg_n, 2 * k_eff() + 3);
      settle();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
